### hw/rtl/ccsa_pkg.sv
// ----------------------------------------------------------------------------
// ccsa_pkg
// Shared widths, op codes, vector type and arctangent table for the
// circular cordic unit.
// ----------------------------------------------------------------------------
package ccsa_pkg;

	localparam int DATA_W    = 32;
	// working width of the x, y and z registers (vectoring growth and sign room)
	localparam int W         = 36;
	// gain multiply is split into a low and a high part of the 36-bit value
	localparam int SPLIT     = 18;
	localparam int PART_W    = 19;
	localparam int KW        = 25;
	localparam int PROD_W    = KW + PART_W;
	localparam int ACC_W     = 62;
	localparam int ROM_LEN   = 30;
	localparam int ROM_SCALE = 30;
	localparam int ROM_IW    = 5;

	typedef enum logic [1:0] {
		OP_SINCOS = 2'd0,
		OP_ATAN   = 2'd1,
		OP_MAG    = 2'd2,
		OP_NONE   = 2'd3
	} ccsa_op_t;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic signed [W-1:0] z;
	} ccsa_vec_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] value;
	} ccsa_gain_rsp_t;

	// floor(atan(2^-i) * 2^30)
	localparam logic [ROM_SCALE-1:0] ATAN_ROM [ROM_LEN] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
		30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
		30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
		30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
		30'd31,        30'd15,        30'd7,         30'd3,         30'd1
	};

	// table entry rounded from 2^30 scale down to the working fraction
	function automatic logic [DATA_W-1:0] atan_val(input logic [ROM_IW-1:0] idx,
			input int frac_bits);
		logic [DATA_W-1:0] e;
		int                s;
		s = ROM_SCALE - frac_bits;
		e = (idx < ROM_IW'(ROM_LEN)) ? DATA_W'(ATAN_ROM[idx]) : '0;
		return (e + (DATA_W'(1) << (s - 1))) >> s;
	endfunction

endpackage

### hw/rtl/ccsa_req_if.sv
// ----------------------------------------------------------------------------
// ccsa_req_if
// Request channel: op code and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccsa_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] x_in;
	logic signed [31:0] y_in;
	logic signed [31:0] angle_in;

	modport source(output valid, output op, output x_in, output y_in, output angle_in,
		input ready);
	modport sink(input valid, input op, input x_in, input y_in, input angle_in,
		output ready);
endinterface

### hw/rtl/ccsa_rsp_if.sv
// ----------------------------------------------------------------------------
// ccsa_rsp_if
// Result channel: value, cosine and error flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccsa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_out;
	logic signed [31:0] cos_out;
	logic               zero_input_error;

	modport source(output valid, output value_out, output cos_out,
		output zero_input_error, input ready);
	modport sink(input valid, input value_out, input cos_out,
		input zero_input_error, output ready);
endinterface

### hw/rtl/ccsa_microrot.sv
// ----------------------------------------------------------------------------
// ccsa_microrot
// Shared micro-rotation unit: one shift-add step of the cordic recurrence
// with half-up rounded shifts and the angle table lookup.
// ----------------------------------------------------------------------------
module ccsa_microrot #(
	parameter int FRAC_BITS = 16,
	parameter int IW        = 4
) (
	input  ccsa_pkg::ccsa_vec_t cur,
	input  logic                rotate,
	input  logic [IW-1:0]       idx,
	output ccsa_pkg::ccsa_vec_t nxt
);
	localparam int W = ccsa_pkg::W;

	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;
	logic signed [W-1:0] ang;
	logic                pos;

	function automatic logic signed [W-1:0] half_shift(input logic signed [W-1:0] v,
			input logic [IW-1:0] s);
		logic signed [W-1:0] t;
		t = (v >>> (s - IW'(1))) + W'(1);
		return (s == '0) ? v : (t >>> 1);
	endfunction

	always_comb begin
		pos = rotate ? !cur.z[W-1] : cur.y[W-1];
		dx  = half_shift(cur.y, idx);
		dy  = half_shift(cur.x, idx);
		ang = W'(ccsa_pkg::atan_val(ccsa_pkg::ROM_IW'(idx), FRAC_BITS));
		if (pos) begin
			nxt.x = cur.x - dx;
			nxt.y = cur.y + dy;
			nxt.z = cur.z - ang;
		end else begin
			nxt.x = cur.x + dx;
			nxt.y = cur.y - dy;
			nxt.z = cur.z + ang;
		end
	end
endmodule

### hw/rtl/ccsa_gain.sv
// ----------------------------------------------------------------------------
// ccsa_gain
// Gain scaling by K1 with round-half-up and 32-bit saturation, done as two
// registered partial products.
// ----------------------------------------------------------------------------
module ccsa_gain #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ccsa_pkg::W-1:0]     v,
	output ccsa_pkg::ccsa_gain_rsp_t          rsp
);
	localparam int W      = ccsa_pkg::W;
	localparam int SPLIT  = ccsa_pkg::SPLIT;
	localparam int PART_W = ccsa_pkg::PART_W;
	localparam int KW     = ccsa_pkg::KW;
	localparam int PROD_W = ccsa_pkg::PROD_W;
	localparam int ACC_W  = ccsa_pkg::ACC_W;
	localparam int DATA_W = ccsa_pkg::DATA_W;
	localparam longint unsigned K1 = (64'd607253 << FRAC_BITS) / 64'd1000000;
	localparam logic signed [KW-1:0]    K1_S = KW'(K1);
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (FRAC_BITS - 1));

	typedef enum logic [3:0] {
		G_IDLE = 4'b0001,
		G_LO   = 4'b0010,
		G_HI   = 4'b0100,
		G_SUM  = 4'b1000
	} gain_ph_t;

	gain_ph_t                  ph_q;
	logic signed [PART_W-1:0]  part;
	logic signed [PART_W-1:0]  hi_q;
	logic signed [PROD_W-1:0]  p_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   r;
	logic                      ovf;

	// low part is unsigned, high part carries the sign
	always_comb begin
		part = start ? PART_W'(signed'({1'b0, v[SPLIT-1:0]})) : hi_q;
		r    = acc_q >>> FRAC_BITS;
		ovf  = !((&r[ACC_W-1:DATA_W-1]) || !(|r[ACC_W-1:DATA_W-1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= G_IDLE;
		end else begin
			case (ph_q)
				G_IDLE:  ph_q <= start ? G_LO : G_IDLE;
				G_LO:    ph_q <= G_HI;
				G_HI:    ph_q <= G_SUM;
				G_SUM:   ph_q <= start ? G_LO : G_IDLE;
				default: ph_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= PART_W'(signed'(v[W-1:SPLIT]));
		end
		if (start || ph_q == G_LO) begin
			p_s1 <= K1_S * part;
		end
		if (ph_q == G_LO) begin
			acc_q <= HALF + ACC_W'(p_s1);
		end else if (ph_q == G_HI) begin
			acc_q <= acc_q + (ACC_W'(p_s1) <<< SPLIT);
		end
	end

	always_comb begin
		rsp.done = (ph_q == G_SUM);
		if (ovf) begin
			rsp.value = r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			rsp.value = r[DATA_W-1:0];
		end
	end
endmodule

### hw/rtl/cordic_circular_sincos_atan_top.sv
// ----------------------------------------------------------------------------
// cordic_circular_sincos_atan_top
// Accept to result valid: iterations then two gain passes for sine/cosine, one
// for magnitude; arctangent prescales (doubling one bit a cycle) and iterates;
// the arctangent of the origin and an unused op code go straight to the result.
// One item at a time through a single shift-add unit and the shared gain
// multiplier; the next request is taken the cycle after the result loads.
// Reset clears the sequencer and the result valid; no data is reset.
// ----------------------------------------------------------------------------
module cordic_circular_sincos_atan_top #(
	parameter int ITERATIONS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ccsa_req_if.sink    req,
	ccsa_rsp_if.source  rsp
);
	localparam int W      = ccsa_pkg::W;
	localparam int DATA_W = ccsa_pkg::DATA_W;
	localparam int IW     = $clog2(ITERATIONS);
	localparam logic signed [W-1:0] ONE  = W'(64'd1 << FRAC_BITS);
	localparam logic signed [W-1:0] HALF = W'(64'd1 << (FRAC_BITS - 1));

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_PRE     = 8'b0000_0010,
		S_ITER    = 8'b0000_0100,
		S_G1_GO   = 8'b0000_1000,
		S_G1_WAIT = 8'b0001_0000,
		S_G2_GO   = 8'b0010_0000,
		S_G2_WAIT = 8'b0100_0000,
		S_FIN     = 8'b1000_0000
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	ccsa_pkg::ccsa_op_t         op_q;
	ccsa_pkg::ccsa_op_t         req_op;
	ccsa_pkg::ccsa_vec_t        vec_q;
	ccsa_pkg::ccsa_vec_t        vec_nxt;
	ccsa_pkg::ccsa_gain_rsp_t   gain_rsp;
	logic [IW-1:0]              i_q;
	logic signed [DATA_W-1:0]   val_q;
	logic signed [DATA_W-1:0]   cos_q;
	logic                       err_q;
	logic                       ov_q;
	logic signed [DATA_W-1:0]   out_val_q;
	logic signed [DATA_W-1:0]   out_cos_q;
	logic                       out_err_q;
	logic                       accept;
	logic                       fin_fire;
	logic                       last_iter;
	logic                       pre_dbl;
	logic                       origin;
	logic                       gain_start;
	logic signed [W-1:0]        gain_v;

	ccsa_microrot #(
		.FRAC_BITS (FRAC_BITS),
		.IW        (IW)
	) u_rot (
		.cur    (vec_q),
		.rotate (op_q == ccsa_pkg::OP_SINCOS),
		.idx    (i_q),
		.nxt    (vec_nxt)
	);

	ccsa_gain #(
		.FRAC_BITS (FRAC_BITS)
	) u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gain_start),
		.v      (gain_v),
		.rsp    (gain_rsp)
	);

	always_comb begin
		req_op     = ccsa_pkg::ccsa_op_t'(req.op);
		req.ready  = (state_q == S_IDLE);
		accept     = req.valid && req.ready;
		fin_fire   = (state_q == S_FIN) && (!ov_q || rsp.ready);
		last_iter  = (i_q == IW'(ITERATIONS - 1));
		origin     = (req.x_in == '0) && (req.y_in == '0);
		// keep doubling while both coordinates sit below half scale
		pre_dbl    = (vec_q.x > -HALF) && (vec_q.x < HALF)
			&& (vec_q.y > -HALF) && (vec_q.y < HALF);
		gain_start = (state_q == S_G1_GO) || (state_q == S_G2_GO);
		// first gain pass takes y for sine, x for magnitude; second pass is cosine
		gain_v     = (state_q == S_G1_GO && op_q == ccsa_pkg::OP_SINCOS) ? vec_q.y : vec_q.x;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_op)
						ccsa_pkg::OP_SINCOS: state_d = S_ITER;
						ccsa_pkg::OP_MAG:    state_d = S_ITER;
						ccsa_pkg::OP_ATAN:   state_d = origin ? S_FIN : S_PRE;
						default:             state_d = S_FIN;
					endcase
				end
			end
			S_PRE: begin
				if (!pre_dbl) state_d = S_ITER;
			end
			S_ITER: begin
				if (last_iter) state_d = (op_q == ccsa_pkg::OP_ATAN) ? S_FIN : S_G1_GO;
			end
			S_G1_GO: state_d = S_G1_WAIT;
			S_G1_WAIT: begin
				if (gain_rsp.done) begin
					state_d = (op_q == ccsa_pkg::OP_SINCOS) ? S_G2_GO : S_FIN;
				end
			end
			S_G2_GO: state_d = S_G2_WAIT;
			S_G2_WAIT: begin
				if (gain_rsp.done) state_d = S_FIN;
			end
			S_FIN: begin
				if (fin_fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_fire) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req_op;
			i_q   <= '0;
			cos_q <= '0;
			err_q <= (req_op == ccsa_pkg::OP_ATAN) && origin;
			val_q <= ((req_op == ccsa_pkg::OP_ATAN) && origin) ? '1 : '0;
			if (req_op == ccsa_pkg::OP_SINCOS) begin
				vec_q.x <= ONE;
				vec_q.y <= '0;
				vec_q.z <= W'(req.angle_in);
			end else begin
				vec_q.x <= W'(req.x_in);
				vec_q.y <= W'(req.y_in);
				vec_q.z <= '0;
			end
		end
		if (state_q == S_PRE && pre_dbl) begin
			vec_q.x <= vec_q.x <<< 1;
			vec_q.y <= vec_q.y <<< 1;
		end
		if (state_q == S_ITER) begin
			vec_q <= vec_nxt;
			i_q   <= i_q + IW'(1);
			if (last_iter && op_q == ccsa_pkg::OP_ATAN) begin
				val_q <= vec_nxt.z[DATA_W-1:0];
			end
		end
		if (state_q == S_G1_WAIT && gain_rsp.done) begin
			val_q <= gain_rsp.value;
		end
		if (state_q == S_G2_WAIT && gain_rsp.done) begin
			cos_q <= gain_rsp.value;
		end
		if (fin_fire) begin
			out_val_q <= val_q;
			out_cos_q <= cos_q;
			out_err_q <= err_q;
		end
	end

	assign rsp.valid            = ov_q;
	assign rsp.value_out        = out_val_q;
	assign rsp.cos_out          = out_cos_q;
	assign rsp.zero_input_error = out_err_q;
endmodule

### bench/cordic_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_result_check
// Passive checker for the circular cordic unit: predicts sine/cosine,
// arctangent and magnitude for every accepted request and compares each
// accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------
module cordic_result_check
	import ccsa_pkg::*;
#(
	parameter int ITERATIONS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	ccsa_req_if  req,
	ccsa_rsp_if  rsp,
	output int   fail_count,
	output int   outstanding,
	output int   checked_count
);

	localparam longint SF          = longint'(1) << FRAC_BITS;
	localparam longint K1          = (longint'(607253) << FRAC_BITS) / 64'sd1000000;
	localparam int     ANGLE_SHIFT = ROM_SCALE - FRAC_BITS;

	typedef struct {
		longint x;
		longint y;
		longint z;
	} wide_vec_t;

	typedef struct {
		ccsa_op_t           op;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] angle;
		logic signed [31:0] value;
		logic signed [31:0] cosine;
		logic               error;
	} cordic_result_t;

	cordic_result_t awaited_results[$];

	// micro-rotation step: shift right by i with rounding by half
	function automatic longint rounded_shift(input longint v, input int i);
		if (i == 0)
			return v;
		return ((v >>> (i - 1)) + 1) >>> 1;
	endfunction

	function automatic longint table_angle(input int i);
		if (i >= ROM_LEN)
			return 0;
		return (longint'(ATAN_ROM[i]) + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
	endfunction

	function automatic longint apply_gain(input longint v);
		longint r;
		r = (K1 * v + SF / 2) >>> FRAC_BITS;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r;
	endfunction

	function automatic longint abs_wide(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// steer by z when rotating, by the sign of y when vectoring
	function automatic wide_vec_t micro_rotations(input wide_vec_t v, input bit by_angle);
		wide_vec_t r;
		longint    dx;
		longint    dy;
		longint    t;
		bit        pos;
		r = v;
		for (int i = 0; i < ITERATIONS; i++) begin
			pos = by_angle ? (r.z >= 0) : (r.y < 0);
			dx  = rounded_shift(r.y, i);
			dy  = rounded_shift(r.x, i);
			t   = table_angle(i);
			if (pos) begin
				r.x -= dx;
				r.y += dy;
				r.z -= t;
			end else begin
				r.x += dx;
				r.y -= dy;
				r.z += t;
			end
		end
		return r;
	endfunction

	function automatic cordic_result_t cordic_predict(input ccsa_op_t op,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] angle);
		cordic_result_t res;
		wide_vec_t      v;
		longint         val;
		longint         cosv;
		val       = 0;
		cosv      = 0;
		res.op    = op;
		res.x     = x;
		res.y     = y;
		res.angle = angle;
		res.error = 1'b0;
		case (op)
			OP_SINCOS: begin
				v.x  = SF;
				v.y  = 0;
				v.z  = longint'(angle);
				v    = micro_rotations(v, 1'b1);
				val  = apply_gain(v.y);
				cosv = apply_gain(v.x);
			end
			OP_ATAN: begin
				if (x == 0 && y == 0) begin
					val       = -1;
					res.error = 1'b1;
				end else begin
					v.x = longint'(x);
					v.y = longint'(y);
					v.z = 0;
					// prescale small vectors so vectoring keeps precision
					while (abs_wide(v.x) < SF / 2 && abs_wide(v.y) < SF / 2) begin
						v.x *= 2;
						v.y *= 2;
					end
					v   = micro_rotations(v, 1'b0);
					val = v.z;
				end
			end
			OP_MAG: begin
				v.x = longint'(x);
				v.y = longint'(y);
				v.z = 0;
				v   = micro_rotations(v, 1'b0);
				val = apply_gain(v.x);
			end
			default: begin
			end
		endcase
		res.value  = val[31:0];
		res.cosine = cosv[31:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin : track
		cordic_result_t want;
		string          tag;
		if (!arst_n) begin
			awaited_results.delete();
			fail_count     = 0;
			outstanding   <= 0;
			checked_count <= 0;
		end else begin
			// results first: a request accepted at this edge cannot answer yet
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d cos %0d err %0b",
						rsp.value_out, rsp.cos_out, rsp.zero_input_error));
				end else begin
					want = awaited_results.pop_front();
					tag  = $sformatf("op %0d x %0d y %0d angle %0d", want.op, want.x,
						want.y, want.angle);
					if (rsp.value_out !== want.value)
						report_mismatch($sformatf("%s: value %0d, predicted %0d", tag,
							rsp.value_out, want.value));
					if (rsp.cos_out !== want.cosine)
						report_mismatch($sformatf("%s: cos %0d, predicted %0d", tag,
							rsp.cos_out, want.cosine));
					if (rsp.zero_input_error !== want.error)
						report_mismatch($sformatf("%s: error flag %0b, predicted %0b", tag,
							rsp.zero_input_error, want.error));
				end
				checked_count <= checked_count + 1;
			end
			if (req.valid && req.ready)
				awaited_results.push_back(cordic_predict(ccsa_op_t'(req.op), req.x_in,
					req.y_in, req.angle_in));
			outstanding <= awaited_results.size();
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the circular cordic unit: directed corner items,
// then random requests of every op, with random idling on both channels outside a steady stretch.
// ----------------------------------------------------------------------------
module tb_top;
	import ccsa_pkg::*;

	localparam int ITERATIONS  = 16;
	localparam int FRAC_BITS   = 16;
	localparam int RANDOM_ITEMS = 1300;
	localparam int STALL_LIMIT = 3000;
	localparam int IDLE_PCT    = 28;
	// pi/2 and pi/4 at the working fraction
	localparam logic signed [31:0] HALF_PI    = 32'sd102944;
	localparam logic signed [31:0] QUARTER_PI = 32'sd51472;
	localparam logic signed [31:0] MAX_WORD   = 32'sh7fffffff;
	localparam logic signed [31:0] MIN_WORD   = 32'sh80000000;
	localparam logic signed [31:0] ONE        = 32'sd65536;

	logic clk;
	logic arst_n;
	logic steady;
	int   fail_count;
	int   outstanding;
	int   checked_count;
	int   sent_per_op[4];
	int   idle_cycles;

	ccsa_req_if req_ch();
	ccsa_rsp_if rsp_ch();

	cordic_circular_sincos_atan_top #(
		.ITERATIONS(ITERATIONS),
		.FRAC_BITS (FRAC_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	cordic_result_check #(
		.ITERATIONS(ITERATIONS),
		.FRAC_BITS (FRAC_BITS)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.checked_count(checked_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	function automatic logic signed [31:0] spread_word();
		logic signed [31:0] w;
		w = $urandom;
		return w >>> $urandom_range(0, 31);
	endfunction

	task automatic send_request(input ccsa_op_t op, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] angle);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.x_in     <= x;
		req_ch.y_in     <= y;
		req_ch.angle_in <= angle;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sent_per_op[op]++;
	endtask

	// hold the sender until every predicted result has come back
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic random_request();
		int                 pick;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] angle;
		pick  = $urandom_range(0, 99);
		x     = $urandom;
		y     = $urandom;
		angle = $urandom;
		if (pick < 5) begin
			send_request(OP_NONE, x, y, angle);
		end else if (pick < 37) begin
			if ($urandom_range(0, 99) < 85)
				angle = int'($urandom_range(0, 228000)) - 114000;
			send_request(OP_SINCOS, x, y, angle);
		end else if (pick < 70) begin
			if ($urandom_range(0, 99) < 3) begin
				x = 0;
				y = 0;
			end else if ($urandom_range(0, 99) < 90) begin
				x = spread_word();
				y = spread_word();
			end
			send_request(OP_ATAN, x, y, angle);
		end else begin
			if ($urandom_range(0, 99) < 85) begin
				x = spread_word();
				y = spread_word();
			end
			send_request(OP_MAG, x, y, angle);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		steady          = 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.op       <= OP_SINCOS;
		req_ch.x_in     <= '0;
		req_ch.y_in     <= '0;
		req_ch.angle_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sine/cosine at zero, quadrant edges and beyond convergence
		send_request(OP_SINCOS, 0, 0, 0);
		send_request(OP_SINCOS, 0, 0, HALF_PI);
		send_request(OP_SINCOS, 0, 0, -HALF_PI);
		send_request(OP_SINCOS, 0, 0, QUARTER_PI);
		send_request(OP_SINCOS, MAX_WORD, MIN_WORD, MAX_WORD);
		send_request(OP_SINCOS, MIN_WORD, MAX_WORD, MIN_WORD);
		// arctangent: origin, deep prescale, negative x, extremes
		send_request(OP_ATAN, 0, 0, 0);
		send_request(OP_ATAN, 1, 0, 0);
		send_request(OP_ATAN, 0, 1, 0);
		send_request(OP_ATAN, -1, -1, 0);
		send_request(OP_ATAN, ONE, ONE, 0);
		send_request(OP_ATAN, -ONE, 0, 0);
		send_request(OP_ATAN, MAX_WORD, MAX_WORD, 0);
		send_request(OP_ATAN, MIN_WORD, MIN_WORD, 0);
		send_request(OP_ATAN, MIN_WORD, MAX_WORD, 0);
		send_request(OP_ATAN, 0, MIN_WORD, 0);
		// magnitude: small, zero, saturating both ways
		send_request(OP_MAG, 3, 4, 0);
		send_request(OP_MAG, 0, 0, 0);
		send_request(OP_MAG, MAX_WORD, MAX_WORD, 0);
		send_request(OP_MAG, MIN_WORD, MIN_WORD, 0);
		send_request(OP_MAG, MIN_WORD, 0, 0);
		// unused op code
		send_request(OP_NONE, MAX_WORD, MIN_WORD, -1);
		send_request(OP_NONE, -1, -1, -1);
		wait_for_drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady <= (n >= 500 && n < 700);
			if (n % 300 == 150)
				wait_for_drain();
			random_request();
		end

		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (ITERATIONS + FRAC_BITS + 10) @(posedge clk);

		$display("covered %0d sine/cosine, %0d arctangent, %0d magnitude, %0d unused-op items",
			sent_per_op[OP_SINCOS], sent_per_op[OP_ATAN], sent_per_op[OP_MAG],
			sent_per_op[OP_NONE]);
		$display("compared %0d result items, %0d mismatches", checked_count, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
